// ----- design/gpc_pkg.sv -----
// ----------------------------------------------------------------------------
// gpc_pkg
// shared widths, constants and types for the grid path counter
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam int MAX_SIZE    = 1024;
  localparam int SIZE_W      = 11;
  localparam int COUNT_W     = 30;
  localparam int IDX_W       = $clog2(MAX_SIZE);
  localparam int CMP_W       = (IDX_W + 1 > SIZE_W) ? IDX_W + 1 : SIZE_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_W-1:0] PATH_MOD = COUNT_W'(1000000007);

  // one classified cell on its way from front to back
  typedef struct packed {
    logic [IDX_W-1:0] slot;
    logic             blocked;
    logic             first_row;
    logic             first_col;
    logic             emit;
  } gpc_item_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic s1_stall;
    logic load;
  } gpc_back_st_t;

endpackage

// ----- design/gpc_ram.sv -----
// ----------------------------------------------------------------------------
// gpc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module gpc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/gpc_front.sv -----
// ----------------------------------------------------------------------------
// gpc_front
// holds grid size and position counters, classifies each incoming cell
// ----------------------------------------------------------------------------
module gpc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [gpc_pkg::SIZE_W-1:0] cfg_wr_data,
  input  logic                      cell_take,
  input  logic                      cell_blocked,
  output gpc_pkg::gpc_item_t        item
);
  import gpc_pkg::*;

  logic [SIZE_W-1:0] grid_size_r;
  logic [IDX_W-1:0]  row_r, row_nxt;
  logic [IDX_W-1:0]  col_r, col_nxt;
  logic [CMP_W-1:0]  size_eff;
  logic              last_col;
  logic              last_row;

  // zero acts as one, oversize clamps to the row buffer depth
  always_comb begin
    if (grid_size_r == '0) begin
      size_eff = CMP_W'(1);
    end else if (CMP_W'(grid_size_r) > CMP_W'(MAX_SIZE)) begin
      size_eff = CMP_W'(MAX_SIZE);
    end else begin
      size_eff = CMP_W'(grid_size_r);
    end
  end

  assign last_col = (CMP_W'(col_r) + CMP_W'(1)) >= size_eff;
  assign last_row = (CMP_W'(row_r) + CMP_W'(1)) >= size_eff;

  always_comb begin
    item.slot      = col_r;
    item.blocked   = cell_blocked;
    item.first_row = (row_r == '0);
    item.first_col = (col_r == '0);
    item.emit      = last_col && last_row;
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    priority if (cfg_wr_en) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (cell_take) begin
      if (!last_col) begin
        col_nxt = col_r + IDX_W'(1);
      end else if (!last_row) begin
        row_nxt = row_r + IDX_W'(1);
        col_nxt = '0;
      end else begin
        row_nxt = '0;
        col_nxt = '0;
      end
    end else begin
      row_nxt = row_r;
      col_nxt = col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= SIZE_W'(1);
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        grid_size_r <= cfg_wr_data;
      end
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// ----- design/gpc_fifo.sv -----
// ----------------------------------------------------------------------------
// gpc_fifo
// short flip-flop queue between front and back
// ----------------------------------------------------------------------------
module gpc_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gpc_pkg::gpc_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output gpc_pkg::gpc_item_t  head_item
);
  import gpc_pkg::*;

  gpc_item_t          slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_r;
  logic [QPTR_W-1:0]  rptr_r;
  logic [QPTR_W:0]    count_r;

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = slots_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ----- design/gpc_back.sv -----
// ----------------------------------------------------------------------------
// gpc_back
// row buffer read, modular add, write back and result register
// ----------------------------------------------------------------------------
module gpc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  gpc_pkg::gpc_item_t          head_item,
  output logic                        pop,
  output logic                        res_valid,
  output logic [gpc_pkg::COUNT_W-1:0] res_count,
  input  logic                        res_ready,
  output gpc_pkg::gpc_back_st_t       status
);
  import gpc_pkg::*;

  logic               s1_valid_r;
  gpc_item_t          s1_item_r;
  logic               s1_go;
  logic [COUNT_W-1:0] below_raw;
  logic [COUNT_W-1:0] below;
  logic [COUNT_W-1:0] right;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] value;
  logic [COUNT_W-1:0] right_count_r;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r;
  logic               load;

  // stage 1 only waits when it has a result and the output is still held
  assign s1_go = s1_valid_r && !(s1_item_r.emit && out_valid_r && !res_ready);
  assign pop   = head_valid && (!s1_valid_r || s1_go);
  assign load  = s1_go && s1_item_r.emit;

  gpc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_SIZE)
  ) u_row_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_item_r.slot),
    .wdata (value),
    .re    (pop),
    .raddr (head_item.slot),
    .rdata (below_raw)
  );

  assign below = s1_item_r.first_row ? '0 : below_raw;
  assign right = s1_item_r.first_col ? '0 : right_count_r;
  assign sum   = {1'b0, below} + {1'b0, right};

  always_comb begin
    priority if (s1_item_r.blocked) begin
      value = '0;
    end else if (s1_item_r.first_row && s1_item_r.first_col) begin
      value = COUNT_W'(1);
    end else if (sum >= {1'b0, PATH_MOD}) begin
      value = COUNT_W'(sum - {1'b0, PATH_MOD});
    end else begin
      value = sum[COUNT_W-1:0];
    end
  end

  always_comb begin
    priority if (load) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item_r <= head_item;
    end
    if (s1_go) begin
      right_count_r <= value;
    end
    if (load) begin
      out_count_r <= value;
    end
  end

  assign res_valid = out_valid_r;
  assign res_count = out_count_r;

  assign status.s1_stall = s1_valid_r && !s1_go;
  assign status.load     = load;

endmodule

// ----- design/grid_path_count_dp_top.sv -----
// ----------------------------------------------------------------------------
// grid_path_count_dp_top
// monotone path counter over a square grid with blocked cells, mod 1e9+7
// ----------------------------------------------------------------------------
// usage
//   in_*  : one beat per grid cell, reverse raster order (last row first,
//           each row from last column to column 0); in_tdata[0] = blocked
//   out_* : one beat per grid, the path count of the start corner,
//           out_tdata[29:0]; no beat for any other cell
//   cfg_* : write enable plus grid side length; writing restarts the grid
//           position, only while the block is idle
// throughput: one cell per cycle sustained while no result is held; the row
//   buffer ram gives one read and one write per cycle, and a four-entry queue
//   decouples the classifying front from the arithmetic back
// result path: queue slot, stage 1 register, then the result register
// reset: synchronous active-low; grid size returns to 1, counters rearm,
//   queue and pipeline empty; the row buffer holds no reset value and its
//   contents are used only after they have been written
// stall: a held result blocks only the next result-bearing cell in the back
//   stage; the queue fills behind it and then in_tready drops
// ----------------------------------------------------------------------------
module grid_path_count_dp_top (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] cell_blocked, [7:1] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [29:0] path_count, [31:30] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data
);
  import gpc_pkg::*;

  logic               fifo_full;
  logic               cell_take;
  gpc_item_t          new_item;
  logic               head_valid;
  gpc_item_t          head_item;
  logic               pop;
  logic [COUNT_W-1:0] res_count;
  gpc_back_st_t       back_st;

  // a beat is taken whenever the queue has room
  assign in_tready = !fifo_full;
  assign cell_take = in_tvalid && in_tready;

  gpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cell_take    (cell_take),
    .cell_blocked (in_tdata[0]),
    .item         (new_item)
  );

  gpc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cell_take),
    .push_item  (new_item),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  gpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .res_valid  (out_tvalid),
    .res_count  (res_count),
    .res_ready  (out_tready),
    .status     (back_st)
  );

  assign out_tdata = {{(32 - COUNT_W){1'b0}}, res_count};

  // the back stage only waits on a held result
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    back_st.s1_stall |-> (out_tvalid && !out_tready))
    else $error("back stage stalled without a held result");

  // a delivered result is not shown again unless a new one was loaded
  a_no_repeat : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !back_st.load) |=> !out_tvalid)
    else $error("result beat repeated");

  // a beat is never taken into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    fifo_full |-> !cell_take)
    else $error("cell taken while queue full");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for grid_path_count_dp_top: streams grids of free and
// blocked cells in reverse raster order, predicts the start-corner path count
// of every complete grid and checks each result beat against it
// ----------------------------------------------------------------------------
module tb;
  import gpc_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // block inputs, all known from time zero
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = 11'd0;

  // stimulus and prediction
  logic [7:0]         cells_pending[$];    // cell beats waiting for the driver
  logic [COUNT_W-1:0] counts_expected[$];  // path counts not yet seen on out_*
  int unsigned        err_cnt = 0;
  int unsigned        cells_sent = 0;
  logic               steady = 1'b0;       // both sides idle-free while set
  logic               pressure_req = 1'b0; // toggle asks for a long hold-off
  logic               pressure_ack = 1'b0;
  int unsigned        hold_left = 0;

  // predictor state: counts of the row below, the cell to the right, position
  logic [COUNT_W-1:0] below_row[MAX_SIZE];
  logic [COUNT_W-1:0] right_q;
  int unsigned        row_q;
  int unsigned        col_q;
  logic [10:0]        side_q;

  grid_path_count_dp_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned side_in_use();
    int unsigned n;
    n = side_q;
    if (n == 0) n = 1;        // a zero side behaves as one cell
    if (n > MAX_SIZE) n = MAX_SIZE;
    return n;
  endfunction

  task automatic restart_grid();
    row_q   = 0;
    col_q   = 0;
    right_q = '0;
  endtask

  // one accepted cell: update the running row of counts, queue the count of
  // the start corner when the grid closes
  task automatic advance_grid(input logic blocked);
    int unsigned      n;
    logic [COUNT_W:0] sum;
    logic [COUNT_W-1:0] cnt;
    n = side_in_use();
    if (col_q >= n || row_q >= n) restart_grid();
    if (blocked) begin
      cnt = '0;
    end else if (row_q == 0 && col_q == 0) begin
      cnt = COUNT_W'(1);       // goal corner seeds the count
    end else begin
      sum = (row_q == 0 ? '0 : {1'b0, below_row[col_q]}) +
            (col_q == 0 ? '0 : {1'b0, right_q});
      if (sum >= {1'b0, PATH_MOD}) sum = sum - {1'b0, PATH_MOD};
      cnt = sum[COUNT_W-1:0];
    end
    below_row[col_q] = cnt;
    right_q = cnt;
    if (col_q + 1 < n) begin
      col_q++;
    end else if (row_q + 1 < n) begin
      row_q++;
      col_q   = 0;
      right_q = '0;
    end else begin
      counts_expected.insert(counts_expected.size(), cnt);
      restart_grid();
    end
  endtask

  // config writes, accepted cells and result beats, all sampled at the edge
  always @(posedge clk) begin
    if (!rst_n) begin
      side_q = 11'd1;
      restart_grid();
    end else begin
      if (cfg_wr_en) begin
        side_q = cfg_wr_data;
        restart_grid();
      end
      if (in_tvalid && in_tready) advance_grid(in_tdata[0]);
      if (out_tvalid && out_tready) begin
        if (counts_expected.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat, expected none, actual %0d",
                   $time, out_tdata);
        end else begin
          logic [COUNT_W-1:0] want;
          want = counts_expected.pop_front();
          if (out_tdata !== {2'b00, want}) begin
            err_cnt++;
            $display("%0t: path_count mismatch, expected %0d, actual %0d",
                     $time, want, out_tdata);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- driver

  // valid is only touched when the previous beat has gone or none was offered
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'd0;
    end else if (!in_tvalid || in_tready) begin
      if (cells_pending.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
        in_tdata  <= cells_pending.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // random back-pressure, plus a long hold-off whenever pressure_req toggles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (pressure_req != pressure_ack) begin
      pressure_ack <= pressure_req;
      hold_left    <= 300;
      out_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || $urandom_range(99) >= 28;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic set_side(input logic [10:0] side);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= side;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_cells(input int unsigned count, input int unsigned blk_pct);
    logic [7:0] beat;
    for (int unsigned i = 0; i < count; i++) begin
      beat = {7'd0, $urandom_range(99) < blk_pct};
      cells_pending.insert(cells_pending.size(), beat);
    end
    cells_sent += count;
  endtask

  task automatic queue_beat(input logic [7:0] beat);
    cells_pending.insert(cells_pending.size(), beat);
    cells_sent++;
  endtask

  // wait until every cell is taken and every count has come back, then let
  // the pipeline settle so a partial grid is fully absorbed
  task automatic drain();
    @(negedge clk);
    while (cells_pending.size() != 0 || in_tvalid || counts_expected.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned grids;
    int unsigned pct;
    int unsigned pick;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-cell grid at the reset side, including unused upper data bits
    queue_beat(8'h00);
    queue_beat(8'h01);
    queue_beat(8'hFE);
    queue_beat(8'hFF);
    drain();

    // side zero behaves as one
    set_side(11'd0);
    queue_beat(8'h00);
    queue_beat(8'h01);
    drain();

    // 2x2 all free, then with the start corner blocked
    set_side(11'd2);
    repeat (4) queue_beat(8'h00);
    repeat (3) queue_beat(8'h00);
    queue_beat(8'h01);
    drain();

    // 3x3 with the centre blocked: two paths
    set_side(11'd3);
    for (int i = 0; i < 9; i++) queue_beat(i == 4 ? 8'h01 : 8'h00);
    drain();

    // hold the receiver while single-cell, then 2x2, grids keep coming: input stalls
    set_side(11'd1);
    pressure_req <= ~pressure_req;
    queue_cells(30, 20);
    drain();
    set_side(11'd2);
    pressure_req <= ~pressure_req;
    queue_cells(40, 10);
    drain();

    // largest side, idle-free, past one full row; then oversize side, each
    // left partial so the next write restarts mid-grid
    steady <= 1'b1;
    set_side(11'd1024);
    queue_cells(1030, 12);
    drain();
    steady <= 1'b0;
    set_side(11'd2047);
    queue_cells(40, 30);
    drain();

    // random grids, mostly small, some large enough to wrap the modulus
    while (cells_sent < 1550) begin
      pick = $urandom_range(99);
      if (pick < 70)      n = $urandom_range(1, 5);
      else if (pick < 90) n = $urandom_range(6, 12);
      else                n = $urandom_range(13, 24);
      grids = (n <= 12) ? $urandom_range(1, 4) : 1;
      pick  = $urandom_range(99);
      pct   = (pick < 15) ? 0 : (pick < 80) ? 12 : 45;
      set_side(n[10:0]);
      queue_cells(grids * n * n, pct);
      if (n > 1 && $urandom_range(99) < 15) queue_cells($urandom_range(1, n * n - 1), pct);
      drain();
    end

    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
